/* rtl/core/ggni_pkg.sv */
// ----------------------------------------------------------------------------
// ggni_pkg
// Shared types and constants of the grid gap neighbor interpolator.
// ----------------------------------------------------------------------------
package ggni_pkg;

  // Default grid extents and stored value width.
  localparam int DEF_MAX_X      = 16;
  localparam int DEF_MAX_Y      = 16;
  localparam int DEF_MAX_Z      = 16;
  localparam int DEF_MAX_T      = 16;
  localparam int DEF_VALUE_BITS = 32;

  // Field widths of the channels.
  localparam int COORD_W = 4;
  localparam int VALUE_W = 32;
  localparam int SIZE_W  = 5;

  // Width of the spatial sum of six signed 32-bit values.
  localparam int SUM_W = 35;

  // Configuration register indexes.
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;
  localparam logic [1:0] REG_SIZE_T = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Operation codes.
  localparam logic OP_WRITE    = 1'b0;
  localparam logic OP_ESTIMATE = 1'b1;

  // Estimate source codes.
  localparam logic [1:0] SRC_NONE     = 2'd0;
  localparam logic [1:0] SRC_SPATIAL  = 2'd1;
  localparam logic [1:0] SRC_TEMP_TWO = 2'd2;
  localparam logic [1:0] SRC_TEMP_ONE = 2'd3;

  // Confidence classes.
  localparam logic [2:0] CLS_NONE    = 3'd0;
  localparam logic [2:0] CLS_ONE     = 3'd1;
  localparam logic [2:0] CLS_FEW     = 3'd2;
  localparam logic [2:0] CLS_MANY    = 3'd3;
  localparam logic [2:0] CLS_PRESENT = 3'd4;

  typedef struct packed {
    logic                       op;
    logic [COORD_W-1:0]         coord_x;
    logic [COORD_W-1:0]         coord_y;
    logic [COORD_W-1:0]         coord_z;
    logic [COORD_W-1:0]         coord_t;
    logic signed [VALUE_W-1:0]  cell_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  estimate;
    logic [1:0]                 source;
    logic [2:0]                 neighbor_count;
    logic [2:0]                 confidence_class;
    logic                       coord_ok;
  } out_item_t;

endpackage

/* rtl/core/ggni_cell_mem.sv */
// ----------------------------------------------------------------------------
// ggni_cell_mem
// Single-port synchronous cell memory holding a presence bit and a value.
// ----------------------------------------------------------------------------
module ggni_cell_mem #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 33
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // One access per cycle; read data is registered.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* rtl/core/ggni_divider.sv */
// ----------------------------------------------------------------------------
// ggni_divider
// Serial signed divider by a small count, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module ggni_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [ggni_pkg::SUM_W-1:0] dividend,
  input  logic [2:0]                       divisor,
  output logic                             done,
  output logic signed [ggni_pkg::SUM_W-1:0] quotient
);
  import ggni_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [SUM_W-1:0] work;
  logic [2:0]       rem;
  logic [2:0]       dvs;
  logic [3:0]       rem_sh;
  logic             ge;
  logic [3:0]       rem_sub;

  // One restoring step on the magnitude.
  always_comb begin
    rem_sh  = {rem, work[SUM_W-1]};
    ge      = (rem_sh >= {1'b0, dvs});
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SUM_W);
        neg  <= dividend[SUM_W-1];
        work <= dividend[SUM_W-1] ? SUM_W'(-dividend) : dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        work <= {work[SUM_W-2:0], ge};
        rem  <= ge ? rem_sub[2:0] : rem_sh[2:0];
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(work) : $signed(work);

endmodule

/* rtl/core/grid_gap_neighbor_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// grid_gap_neighbor_interpolator_unit
// Four-dimensional cell grid with presence bits and gap estimation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one operation per
//   transfer: a write stores a value and marks the cell present, an
//   estimate averages present spatial neighbors when two or more are
//   present, or else falls back to the nearest present cells along t.
//   Every transfer yields one result on out_valid/out_stall/out_data.
//   Work is one item at a time, sequenced over the single memory port:
//   a write or out-of-grid item passes the write and finishing states,
//   an estimate reads 13 cells (one per cycle), drains, decides, and
//   waits on the serial divider when two or more neighbors are present.
//   Sizes are to be written through the APB port only while the block
//   is idle; the block itself does not enforce this. After reset the
//   presence bits are swept clear, one cell per cycle, over all
//   2**(address bits) cells (65536 with default sizes); in_stall stays
//   high until the sweep ends. The result register lets the next item
//   be taken while a finished result waits; a stalled receiver holds
//   the result and eventually blocks completion of the following item.
// ----------------------------------------------------------------------------
module grid_gap_neighbor_interpolator_unit #(
  parameter int MAX_X      = ggni_pkg::DEF_MAX_X,
  parameter int MAX_Y      = ggni_pkg::DEF_MAX_Y,
  parameter int MAX_Z      = ggni_pkg::DEF_MAX_Z,
  parameter int MAX_T      = ggni_pkg::DEF_MAX_T,
  parameter int VALUE_BITS = ggni_pkg::DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  ggni_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ggni_pkg::out_item_t out_data
);
  import ggni_pkg::*;

  localparam int AW_X   = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int AW_Y   = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int AW_Z   = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
  localparam int AW_T   = (MAX_T > 1) ? $clog2(MAX_T) : 1;
  localparam int ADDR_W = AW_X + AW_Y + AW_Z + AW_T;
  localparam int VAL_W  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int DATA_W = VAL_W + 1;
  localparam int EXT_W  = 9;
  localparam int CW     = SIZE_W;

  localparam logic [EXT_W-1:0] LIM_X = EXT_W'(MAX_X);
  localparam logic [EXT_W-1:0] LIM_Y = EXT_W'(MAX_Y);
  localparam logic [EXT_W-1:0] LIM_Z = EXT_W'(MAX_Z);
  localparam logic [EXT_W-1:0] LIM_T = EXT_W'(MAX_T);

  // Read slots of one estimate.
  localparam logic [3:0] SLOT_CENTER = 4'd0;
  localparam logic [3:0] SLOT_XM     = 4'd1;
  localparam logic [3:0] SLOT_XP     = 4'd2;
  localparam logic [3:0] SLOT_YM     = 4'd3;
  localparam logic [3:0] SLOT_YP     = 4'd4;
  localparam logic [3:0] SLOT_ZM     = 4'd5;
  localparam logic [3:0] SLOT_ZP     = 4'd6;
  localparam logic [3:0] SLOT_TM1    = 4'd7;
  localparam logic [3:0] SLOT_TM2    = 4'd8;
  localparam logic [3:0] SLOT_TM3    = 4'd9;
  localparam logic [3:0] SLOT_TP1    = 4'd10;
  localparam logic [3:0] SLOT_TP2    = 4'd11;
  localparam logic [3:0] SLOT_TP3    = 4'd12;

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_WRITE  = 8'b0000_0100,
    ST_RUN    = 8'b0000_1000,
    ST_DRAIN  = 8'b0001_0000,
    ST_DECIDE = 8'b0010_0000,
    ST_DIV    = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [SIZE_W-1:0] size_x, size_y, size_z, size_t_axis;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= SIZE_RESET;
      size_y      <= SIZE_RESET;
      size_z      <= SIZE_RESET;
      size_t_axis <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SIZE_X: size_x      <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y: size_y      <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z: size_z      <= pwdata[SIZE_W-1:0];
        REG_SIZE_T: size_t_axis <= pwdata[SIZE_W-1:0];
        default:    size_x      <= size_x;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SIZE_X: prdata = 32'(size_x);
      REG_SIZE_Y: prdata = 32'(size_y);
      REG_SIZE_Z: prdata = 32'(size_z);
      REG_SIZE_T: prdata = 32'(size_t_axis);
      default:    prdata = '0;
    endcase
  end

  // Usable extents, clamped to the grid.
  logic [EXT_W-1:0] ext_x, ext_y, ext_z, ext_t;
  always_comb begin
    ext_x = (EXT_W'(size_x) < LIM_X) ? EXT_W'(size_x) : LIM_X;
    ext_y = (EXT_W'(size_y) < LIM_Y) ? EXT_W'(size_y) : LIM_Y;
    ext_z = (EXT_W'(size_z) < LIM_Z) ? EXT_W'(size_z) : LIM_Z;
    ext_t = (EXT_W'(size_t_axis) < LIM_T) ? EXT_W'(size_t_axis) : LIM_T;
  end

  // Item registers.
  logic                 op_r;
  logic [CW-1:0]        cx, cy, cz, ct;
  logic [VAL_W-1:0]     val_r;
  logic                 ok_r;
  logic                 in_ok;

  assign in_ok = (EXT_W'(in_data.coord_x) < ext_x) && (EXT_W'(in_data.coord_y) < ext_y) &&
                 (EXT_W'(in_data.coord_z) < ext_z) && (EXT_W'(in_data.coord_t) < ext_t);

  // Slot address generation.
  logic [3:0]    slot;
  logic [CW-1:0] nx, ny, nz, nt;
  logic          slot_ok;

  always_comb begin
    nx      = cx;
    ny      = cy;
    nz      = cz;
    nt      = ct;
    slot_ok = 1'b1;
    case (slot)
      SLOT_CENTER: slot_ok = 1'b1;
      SLOT_XM: begin
        nx = cx - 1'b1;  slot_ok = (cx != '0);
      end
      SLOT_XP: begin
        nx = cx + 1'b1;  slot_ok = (EXT_W'(cx) + 1'b1 < ext_x);
      end
      SLOT_YM: begin
        ny = cy - 1'b1;  slot_ok = (cy != '0);
      end
      SLOT_YP: begin
        ny = cy + 1'b1;  slot_ok = (EXT_W'(cy) + 1'b1 < ext_y);
      end
      SLOT_ZM: begin
        nz = cz - 1'b1;  slot_ok = (cz != '0);
      end
      SLOT_ZP: begin
        nz = cz + 1'b1;  slot_ok = (EXT_W'(cz) + 1'b1 < ext_z);
      end
      SLOT_TM1: begin
        nt = ct - CW'(1); slot_ok = (ct >= CW'(1));
      end
      SLOT_TM2: begin
        nt = ct - CW'(2); slot_ok = (ct >= CW'(2));
      end
      SLOT_TM3: begin
        nt = ct - CW'(3); slot_ok = (ct >= CW'(3));
      end
      SLOT_TP1: begin
        nt = ct + CW'(1); slot_ok = (EXT_W'(ct) + EXT_W'(1) < ext_t);
      end
      SLOT_TP2: begin
        nt = ct + CW'(2); slot_ok = (EXT_W'(ct) + EXT_W'(2) < ext_t);
      end
      SLOT_TP3: begin
        nt = ct + CW'(3); slot_ok = (EXT_W'(ct) + EXT_W'(3) < ext_t);
      end
      default: slot_ok = 1'b0;
    endcase
  end

  // Coordinates resized to the address fields of each axis.
  logic [CW+AW_X-1:0] fx;
  logic [CW+AW_Y-1:0] fy;
  logic [CW+AW_Z-1:0] fz;
  logic [CW+AW_T-1:0] ft;
  logic [ADDR_W-1:0]  cell_addr;

  always_comb begin
    fx        = {{AW_X{1'b0}}, nx};
    fy        = {{AW_Y{1'b0}}, ny};
    fz        = {{AW_Z{1'b0}}, nz};
    ft        = {{AW_T{1'b0}}, nt};
    cell_addr = {ft[AW_T-1:0], fz[AW_Z-1:0], fy[AW_Y-1:0], fx[AW_X-1:0]};
  end

  // Memory port.
  logic              mem_en, mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;
  logic [ADDR_W:0]   clr_cnt;

  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = cell_addr;
    mem_wdata = {1'b1, val_r};
    case (state)
      ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_cnt[ADDR_W-1:0];
        mem_wdata = '0;
      end
      ST_WRITE: begin
        mem_en = ok_r && (op_r == OP_WRITE);
        mem_we = 1'b1;
      end
      ST_RUN:  mem_en = 1'b1;
      default: mem_en = 1'b0;
    endcase
  end

  ggni_cell_mem #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Gathered values.
  logic                    rd_live;
  logic [3:0]              rd_slot;
  logic                    rd_ok;
  logic                    rd_hit;
  logic signed [SUM_W-1:0] rd_val;
  logic signed [SUM_W-1:0] sum;
  logic [2:0]              count;
  logic                    center_hit;
  logic                    hb, ha;
  logic signed [SUM_W-1:0] before_v, after_v;
  logic signed [SUM_W-1:0] est_r;
  logic [1:0]              src_r;

  assign rd_hit = rd_live && rd_ok && mem_rdata[VAL_W];
  assign rd_val = SUM_W'($signed(mem_rdata[VAL_W-1:0]));

  // Temporal mean, truncated toward zero.
  logic signed [SUM_W-1:0] pair_sum, pair_avg;
  always_comb begin
    pair_sum = before_v + after_v;
    pair_avg = $signed(pair_sum + SUM_W'(pair_sum[SUM_W-1] & pair_sum[0])) >>> 1;
  end

  // Divider for the spatial mean.
  logic                    div_start, div_done;
  logic signed [SUM_W-1:0] div_q;

  assign div_start = (state == ST_DECIDE) && (count >= 3'd2);

  ggni_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_q)
  );

  // Confidence class of the finished item.
  logic [2:0] cls;
  always_comb begin
    if (center_hit)          cls = CLS_PRESENT;
    else if (count >= 3'd4)  cls = CLS_MANY;
    else if (count >= 3'd2)  cls = CLS_FEW;
    else if (count == 3'd1)  cls = CLS_ONE;
    else                     cls = CLS_NONE;
  end

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      rd_live   <= 1'b0;
    end else begin
      rd_live <= (state == ST_RUN);
      rd_slot <= slot;
      rd_ok   <= slot_ok;
      // The finishing state reloads the result register itself.
      if (out_valid && !out_stall && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      // Gather read results in the cycle after each read.
      if (rd_hit) begin
        case (rd_slot)
          SLOT_CENTER: center_hit <= 1'b1;
          SLOT_XM, SLOT_XP, SLOT_YM, SLOT_YP, SLOT_ZM, SLOT_ZP: begin
            sum   <= sum + rd_val;
            count <= count + 1'b1;
          end
          SLOT_TM1, SLOT_TM2, SLOT_TM3: begin
            if (!hb) begin
              hb       <= 1'b1;
              before_v <= rd_val;
            end
          end
          SLOT_TP1, SLOT_TP2, SLOT_TP3: begin
            if (!ha) begin
              ha      <= 1'b1;
              after_v <= rd_val;
            end
          end
          default: center_hit <= center_hit;
        endcase
      end

      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (ADDR_W+1)'((2**ADDR_W) - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            op_r       <= in_data.op;
            cx         <= CW'(in_data.coord_x);
            cy         <= CW'(in_data.coord_y);
            cz         <= CW'(in_data.coord_z);
            ct         <= CW'(in_data.coord_t);
            val_r      <= in_data.cell_value[VAL_W-1:0];
            ok_r       <= in_ok;
            slot       <= SLOT_CENTER;
            sum        <= '0;
            count      <= '0;
            center_hit <= 1'b0;
            hb         <= 1'b0;
            ha         <= 1'b0;
            est_r      <= '0;
            src_r      <= SRC_NONE;
            if (in_ok && (in_data.op == OP_ESTIMATE)) begin
              state <= ST_RUN;
            end else begin
              state <= ST_WRITE;
            end
          end
        end
        ST_WRITE: state <= ST_FINISH;
        ST_RUN: begin
          slot <= slot + 1'b1;
          if (slot == SLOT_TP3) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_DECIDE;
        ST_DECIDE: begin
          if (count >= 3'd2) begin
            state <= ST_DIV;
          end else begin
            if (hb && ha) begin
              est_r <= pair_avg;
              src_r <= SRC_TEMP_TWO;
            end else if (hb) begin
              est_r <= before_v;
              src_r <= SRC_TEMP_ONE;
            end else if (ha) begin
              est_r <= after_v;
              src_r <= SRC_TEMP_ONE;
            end
            state <= ST_FINISH;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            est_r <= div_q;
            src_r <= SRC_SPATIAL;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid                 <= 1'b1;
            out_data.estimate         <= est_r[VALUE_W-1:0];
            out_data.source           <= src_r;
            out_data.neighbor_count   <= count;
            out_data.confidence_class <= cls;
            out_data.coord_ok         <= ok_r;
            state                     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The memory is written only by the clearing sweep or a write item.
  a_mem_write_src: assert property (@(posedge clk) disable iff (rst)
    (mem_en && mem_we) |-> (state == ST_CLEAR || state == ST_WRITE))
    else $error("memory written outside clear or write");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside its wait state");

  // At most six spatial neighbors are ever counted.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) |-> (count <= 3'd6))
    else $error("neighbor count above six");

  // A new result is loaded only from the finishing state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result loaded outside finishing state");

endmodule

/* verif/grid_gap_neighbor_interpolator_unit_tb.sv */
// ----------------------------------------------------------------------------
// grid_gap_neighbor_interpolator_unit_tb
// Self-checking bench for the gap interpolator. A directed table covers the
// value extremes, both operations, spatial and temporal estimation and the
// empty grid. Random write/estimate traffic then runs over several grid
// sizes, including the smallest axis, zero sizes and clamped sizes. Every
// result is compared against an in-bench grid model or a typed table row.
// ----------------------------------------------------------------------------
module grid_gap_neighbor_interpolator_unit_tb;
  import ggni_pkg::*;

  localparam int CELL_COUNT = 65536;
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD = 400;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;

  // Shadow copy of the grid contents and the configured sizes.
  logic signed [31:0] grid_value [CELL_COUNT];
  bit                 grid_present [CELL_COUNT];
  logic [4:0]         size_reg [4];

  out_item_t  pending_results [$];
  int         error_count;
  int         tx_idle_pct;
  int         rx_idle_pct;
  bit         hold_request;
  int         hold_left;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } table_row_t;

  table_row_t directed_rows [$];

  grid_gap_neighbor_interpolator_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(8 * 3000000);
    $display("grid_gap_neighbor_interpolator_unit_tb: done, errors");
    $finish;
  end

  function automatic int usable(int idx);
    return (size_reg[idx] < 16) ? int'(size_reg[idx]) : 16;
  endfunction

  function automatic int cell_addr(int x, int y, int z, int t);
    return ((t * 16 + z) * 16 + y) * 16 + x;
  endfunction

  // Computes the result of one transfer and updates the shadow grid.
  function automatic out_item_t interpolate(in_item_t it);
    out_item_t r;
    int ex, ey, ez, et, x, y, z, t, n, count, a;
    int crd [3];
    int lim [3];
    longint sum, prev_val, next_val;
    bit found_prev, found_next;
    ex = usable(0); ey = usable(1); ez = usable(2); et = usable(3);
    x = it.coord_x; y = it.coord_y; z = it.coord_z; t = it.coord_t;
    r = '0;
    r.coord_ok = (x < ex) && (y < ey) && (z < ez) && (t < et);
    if (!r.coord_ok) return r;
    if (it.op == OP_WRITE) begin
      grid_value[cell_addr(x, y, z, t)] = it.cell_value;
      grid_present[cell_addr(x, y, z, t)] = 1'b1;
      return r;
    end
    // Six spatial neighbors on the same time slice.
    sum = 0;
    count = 0;
    lim[0] = ex; lim[1] = ey; lim[2] = ez;
    for (n = 0; n < 6; n++) begin
      crd[0] = x; crd[1] = y; crd[2] = z;
      if (n % 2 == 1) begin
        if (crd[n / 2] + 1 >= lim[n / 2]) continue;
        crd[n / 2]++;
      end else begin
        if (crd[n / 2] == 0) continue;
        crd[n / 2]--;
      end
      a = cell_addr(crd[0], crd[1], crd[2], t);
      if (grid_present[a]) begin
        sum += grid_value[a];
        count++;
      end
    end
    if (count >= 2) begin
      r.estimate = 32'(sum / count);
      r.source = SRC_SPATIAL;
    end else begin
      // Nearest present cell up to three slices back and forward.
      found_prev = 0; found_next = 0; prev_val = 0; next_val = 0;
      for (n = 1; n <= 3 && n <= t && !found_prev; n++) begin
        a = cell_addr(x, y, z, t - n);
        if (grid_present[a]) begin
          prev_val = grid_value[a];
          found_prev = 1;
        end
      end
      for (n = 1; n <= 3 && t + n < et && !found_next; n++) begin
        a = cell_addr(x, y, z, t + n);
        if (grid_present[a]) begin
          next_val = grid_value[a];
          found_next = 1;
        end
      end
      if (found_prev && found_next) begin
        r.estimate = 32'((prev_val + next_val) / 2);
        r.source = SRC_TEMP_TWO;
      end else if (found_prev) begin
        r.estimate = 32'(prev_val);
        r.source = SRC_TEMP_ONE;
      end else if (found_next) begin
        r.estimate = 32'(next_val);
        r.source = SRC_TEMP_ONE;
      end
    end
    r.neighbor_count = 3'(count);
    if (grid_present[cell_addr(x, y, z, t)]) r.confidence_class = CLS_PRESENT;
    else if (count >= 4) r.confidence_class = CLS_MANY;
    else if (count >= 2) r.confidence_class = CLS_FEW;
    else if (count == 1) r.confidence_class = CLS_ONE;
    else r.confidence_class = CLS_NONE;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, want %0d", field, got, want);
    error_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.estimate !== want.estimate)
          report_mismatch("estimate", out_data.estimate, want.estimate);
        if (out_data.source !== want.source)
          report_mismatch("source", out_data.source, want.source);
        if (out_data.neighbor_count !== want.neighbor_count)
          report_mismatch("neighbor_count", out_data.neighbor_count, want.neighbor_count);
        if (out_data.confidence_class !== want.confidence_class)
          report_mismatch("confidence_class", out_data.confidence_class,
                          want.confidence_class);
        if (out_data.coord_ok !== want.coord_ok)
          report_mismatch("coord_ok", out_data.coord_ok, want.coord_ok);
      end
    end
  end

  // Receiver stall: random idling, or a long hold-off counted here.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Offers one item, with random gaps first, and waits for its transfer.
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = interpolate(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB register write, setup then access phase; only called while the block is idle.
  task automatic write_size(logic [1:0] idx, logic [4:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(idx) << 2;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    size_reg[idx] = value;
  endtask

  task automatic set_sizes(int sx, int sy, int sz, int st);
    write_size(REG_SIZE_X, 5'(sx));
    write_size(REG_SIZE_Y, 5'(sy));
    write_size(REG_SIZE_Z, 5'(sz));
    write_size(REG_SIZE_T, 5'(st));
  endtask

  function automatic logic [3:0] pick_coord(int ext);
    if (ext == 0 || $urandom_range(0, 99) < 8) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, ext - 1));
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.op = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_ESTIMATE;
    it.coord_x = pick_coord(usable(0));
    it.coord_y = pick_coord(usable(1));
    it.coord_z = pick_coord(usable(2));
    it.coord_t = pick_coord(usable(3));
    case ($urandom_range(0, 3))
      0: it.cell_value = $urandom();
      1: it.cell_value = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: it.cell_value = 32'($urandom_range(0, 4000)) - 32'sd2000;
    endcase
    return it;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_item(random_item(), 1'b0, '0);
  endtask

  task automatic add_row(logic op, int x, int y, int z, int t, logic [31:0] value,
                         bit typed = 0, logic [1:0] src = SRC_NONE,
                         logic [2:0] cls = CLS_NONE);
    table_row_t row;
    row.item = '{op, 4'(x), 4'(y), 4'(z), 4'(t), value};
    row.typed = typed;
    row.want = '{32'sd0, src, 3'd0, cls, 1'b1};
    directed_rows.push_back(row);
  endtask

  // Main sequence.
  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    error_count = 0;
    hold_request = 1'b0;
    hold_left = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 4; i++) size_reg[i] = SIZE_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the full default grid.
    add_row(OP_ESTIMATE, 0, 0, 0, 0, 0, 1);                  // empty grid
    add_row(OP_WRITE, 0, 0, 0, 0, 32'h7FFF_FFFF, 1);         // max value
    add_row(OP_WRITE, 15, 15, 15, 15, 32'h8000_0000, 1);     // min value
    add_row(OP_ESTIMATE, 15, 15, 15, 15, 0);                 // present, alone
    add_row(OP_WRITE, 1, 0, 0, 0, 100);
    add_row(OP_ESTIMATE, 2, 0, 0, 0, 0);                     // one neighbor
    add_row(OP_WRITE, 0, 1, 0, 0, -300);
    add_row(OP_ESTIMATE, 0, 0, 0, 0, 0);                     // spatial mean
    add_row(OP_WRITE, 0, 0, 1, 0, 1);
    add_row(OP_ESTIMATE, 0, 0, 0, 0, 0);                     // truncated mean
    add_row(OP_ESTIMATE, 1, 1, 0, 0, 0);
    add_row(OP_WRITE, 5, 5, 5, 2, 7);
    add_row(OP_WRITE, 5, 5, 5, 6, -4);
    add_row(OP_ESTIMATE, 5, 5, 5, 4, 0);                     // both slices
    add_row(OP_WRITE, 6, 6, 6, 1, -5);
    add_row(OP_WRITE, 6, 6, 6, 3, 0);
    add_row(OP_ESTIMATE, 6, 6, 6, 2, 0);                     // negative odd mean
    add_row(OP_ESTIMATE, 5, 5, 5, 9, 0);                     // one slice back
    add_row(OP_ESTIMATE, 5, 5, 5, 10, 0);                    // too far back
    add_row(OP_ESTIMATE, 15, 15, 15, 14, 0);                 // one slice forward
    add_row(OP_WRITE, 15, 14, 15, 15, 32'h8000_0000);
    add_row(OP_WRITE, 14, 15, 15, 15, 32'h8000_0000);
    add_row(OP_ESTIMATE, 15, 15, 15, 15, 0);                 // extreme sum
    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    drain();

    // Small grid, slow receiver.
    tx_idle_pct = 18;
    rx_idle_pct = 80;
    set_sizes(4, 3, 2, 6);
    send_random(300);
    drain();

    // Clamped x, single y row, slow sender.
    tx_idle_pct = 80;
    rx_idle_pct = 18;
    set_sizes(31, 1, 16, 3);
    send_random(230);
    drain();

    // Zero-sized axis: everything lies outside.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_sizes(0, 2, 2, 2);
    send_random(20);
    drain();

    // Tiny grid at full rate, with a long receiver hold-off to fill up.
    set_sizes(2, 2, 2, 16);
    hold_request = 1'b1;
    send_random(140);
    drain();
    send_random(140);
    drain();

    if (error_count == 0) begin
      $display("grid_gap_neighbor_interpolator_unit_tb: done, clean");
    end else begin
      $display("grid_gap_neighbor_interpolator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ggni_pkg.sv
rtl/core/ggni_cell_mem.sv
rtl/core/ggni_divider.sv
rtl/core/grid_gap_neighbor_interpolator_unit.sv
verif/grid_gap_neighbor_interpolator_unit_tb.sv
